>>> rtl/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types, widths and helpers of the incremental pid speed loop
// ----------------------------------------------------------------------------
package ipid_pkg;

  // controller channels, one per wheel
  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // datapath widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 16;
  localparam int ERR_W   = SPEED_W + 1;  // target - measured
  localparam int DIFF_W  = ERR_W + 1;    // e - e1
  localparam int DDIFF_W = ERR_W + 2;    // e - 2*e1 + e2
  localparam int PROD_W  = 35;           // gain * second difference
  localparam int MAG_W   = PROD_W - 1;
  localparam int QMAG_W  = 31;           // |product| / 10
  localparam int QUOT_W  = QMAG_W + 1;
  localparam int SUM_W   = QUOT_W + 2;   // accumulator plus three terms
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7200);

  // split constants for the divide by ten
  localparam int            DIV_LO_W  = 17;
  localparam logic [13:0]   DIV_HI_Q  = 14'd13107;   // 2^17 = 10*13107 + 2
  localparam int            DIV_SHIFT = 22;
  localparam logic [18:0]   DIV_RECIP = 19'd419431;  // ceil(2^22 / 10)

  typedef logic [CH_W-1:0] ch_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_LIMIT  = 2'd3
  } cfg_reg_t;

  // floor(m / 10) for a magnitude below 2^34, no divider
  function automatic logic [QMAG_W-1:0] div10_mag(input logic [MAG_W-1:0] m);
    logic [DIV_LO_W-1:0] hi;
    logic [DIV_LO_W-1:0] lo;
    logic [18:0]         x;
    logic [30:0]         q_hi;
    logic [37:0]         q_x;
    hi   = m[MAG_W-1:DIV_LO_W];
    lo   = m[DIV_LO_W-1:0];
    x    = {1'b0, hi, 1'b0} + {2'b00, lo};
    q_hi = 31'(hi) * 31'(DIV_HI_Q);
    q_x  = 38'(x) * 38'(DIV_RECIP);
    return QMAG_W'(q_hi + 31'(q_x[37:DIV_SHIFT]));
  endfunction

endpackage

>>> rtl/incremental_pid_speed_loop.sv
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop
// Two-channel incremental (velocity form) pid speed controller
// ----------------------------------------------------------------------------
// Each transaction on the input stream names a wheel (tuser) and carries the
// measured and target speed (tdata). The block forms the error, its first and
// second differences against that wheel's two stored past errors, adds
// kp*d/10 + ki*e/10 + kd*dd/10 (each term truncated toward zero) to the
// wheel's drive accumulator, clamps it to +/- output_limit and returns it.
// One transaction is accepted every clock cycle while the result stream is
// not stalled; a result passes through the four-register pipeline (input,
// products, quotients, result). The error history is updated as an
// item leaves the input register and the accumulator as it enters the result
// register, so items of the same wheel may follow each other in consecutive
// cycles. Configuration registers are written through the cfg port, which is
// always ready; write them only while no transaction is in flight.
module incremental_pid_speed_loop (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] measured_speed, [31:16] target_speed
  input  logic [0:0]  in_tuser,   // [0] wheel
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] drive_value
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ipid_pkg::GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [ipid_pkg::LIMIT_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      limit_r  <= ipid_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ipid_pkg::cfg_reg_t'(cfg_index))
        ipid_pkg::REG_GAIN_P: gain_p_r <= cfg_data;
        ipid_pkg::REG_GAIN_I: gain_i_r <= cfg_data;
        ipid_pkg::REG_GAIN_D: gain_d_r <= cfg_data;
        ipid_pkg::REG_LIMIT:  limit_r  <= cfg_data[ipid_pkg::LIMIT_W-1:0];
        default:              limit_r  <= limit_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: each stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3;
  logic mv0, mv1, mv2, mv3;

  assign rdy3 = !out_valid_r || out_tready;
  assign rdy2 = !s2_valid_r  || rdy3;
  assign rdy1 = !s1_valid_r  || rdy2;
  assign rdy0 = !s0_valid_r  || rdy1;

  assign mv0 = in_tvalid && rdy0;   // input  -> s0
  assign mv1 = s0_valid_r && rdy1;  // s0     -> s1 (history update)
  assign mv2 = s1_valid_r && rdy2;  // s1     -> s2
  assign mv3 = s2_valid_r && rdy3;  // s2     -> result (accumulator update)

  assign in_tready  = rdy0;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= mv0 || (s0_valid_r  && !mv1);
      s1_valid_r  <= mv1 || (s1_valid_r  && !mv2);
      s2_valid_r  <= mv2 || (s2_valid_r  && !mv3);
      out_valid_r <= mv3 || (out_valid_r && !out_tready);
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register
  // --------------------------------------------------------------------------
  ipid_pkg::ch_t                       s0_ch_r;
  logic signed [ipid_pkg::SPEED_W-1:0] s0_meas_r, s0_targ_r;

  always_ff @(posedge clk) begin
    if (mv0) begin
      s0_ch_r   <= ipid_pkg::CH_W'(in_tuser % ipid_pkg::CHANNELS);
      s0_meas_r <= in_tdata[15:0];
      s0_targ_r <= in_tdata[31:16];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: error, differences and the three gain products
  // --------------------------------------------------------------------------
  logic signed [ipid_pkg::ERR_W-1:0] prev_err_r  [ipid_pkg::CHANNELS];
  logic signed [ipid_pkg::ERR_W-1:0] prev2_err_r [ipid_pkg::CHANNELS];

  logic signed [ipid_pkg::ERR_W-1:0]   err, e1, e2;
  logic signed [ipid_pkg::DIFF_W-1:0]  diff1;
  logic signed [ipid_pkg::DDIFF_W-1:0] diff2;
  logic signed [ipid_pkg::PROD_W-1:0]  prod_p, prod_i, prod_d;

  always_comb begin
    err    = ipid_pkg::ERR_W'(s0_targ_r) - ipid_pkg::ERR_W'(s0_meas_r);
    e1     = prev_err_r[s0_ch_r];
    e2     = prev2_err_r[s0_ch_r];
    diff1  = ipid_pkg::DIFF_W'(err) - ipid_pkg::DIFF_W'(e1);
    diff2  = ipid_pkg::DDIFF_W'(err) - (ipid_pkg::DDIFF_W'(e1) <<< 1)
           + ipid_pkg::DDIFF_W'(e2);
    prod_p = $signed({1'b0, gain_p_r}) * diff1;
    prod_i = $signed({1'b0, gain_i_r}) * err;
    prod_d = $signed({1'b0, gain_d_r}) * diff2;
  end

  // error history shifts as the item leaves stage 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ipid_pkg::CHANNELS; i++) begin
        prev_err_r[i]  <= '0;
        prev2_err_r[i] <= '0;
      end
    end else if (mv1) begin
      prev2_err_r[s0_ch_r] <= e1;
      prev_err_r[s0_ch_r]  <= err;
    end
  end

  ipid_pkg::ch_t                      s1_ch_r;
  logic signed [ipid_pkg::PROD_W-1:0] s1_prod_p_r, s1_prod_i_r, s1_prod_d_r;

  always_ff @(posedge clk) begin
    if (mv1) begin
      s1_ch_r     <= s0_ch_r;
      s1_prod_p_r <= prod_p;
      s1_prod_i_r <= prod_i;
      s1_prod_d_r <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: each product divided by ten, truncated toward zero
  // --------------------------------------------------------------------------
  function automatic logic signed [ipid_pkg::QUOT_W-1:0] div10_trunc(
    input logic signed [ipid_pkg::PROD_W-1:0] p
  );
    logic                          neg;
    logic [ipid_pkg::MAG_W-1:0]    mag;
    logic [ipid_pkg::QMAG_W-1:0]   q;
    logic [ipid_pkg::QUOT_W-1:0]   qs;
    neg = p[ipid_pkg::PROD_W-1];
    mag = neg ? ipid_pkg::MAG_W'(-p) : ipid_pkg::MAG_W'(p);
    q   = ipid_pkg::div10_mag(mag);
    qs  = {1'b0, q};
    return neg ? $signed(-qs) : $signed(qs);
  endfunction

  ipid_pkg::ch_t                      s2_ch_r;
  logic signed [ipid_pkg::QUOT_W-1:0] s2_q_p_r, s2_q_i_r, s2_q_d_r;

  always_ff @(posedge clk) begin
    if (mv2) begin
      s2_ch_r  <= s1_ch_r;
      s2_q_p_r <= div10_trunc(s1_prod_p_r);
      s2_q_i_r <= div10_trunc(s1_prod_i_r);
      s2_q_d_r <= div10_trunc(s1_prod_d_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: accumulate, clamp, store and present the drive value
  // --------------------------------------------------------------------------
  logic signed [ipid_pkg::DRIVE_W-1:0] acc_r [ipid_pkg::CHANNELS];
  logic signed [ipid_pkg::SUM_W-1:0]   sum, lim_pos, lim_neg;
  logic signed [ipid_pkg::DRIVE_W-1:0] clamped;
  logic [ipid_pkg::DRIVE_W-1:0]        out_drive_r;

  always_comb begin
    sum     = ipid_pkg::SUM_W'(acc_r[s2_ch_r])
            + ipid_pkg::SUM_W'(s2_q_p_r)
            + ipid_pkg::SUM_W'(s2_q_i_r)
            + ipid_pkg::SUM_W'(s2_q_d_r);
    lim_pos = $signed({{(ipid_pkg::SUM_W-ipid_pkg::LIMIT_W){1'b0}}, limit_r});
    lim_neg = -lim_pos;
    priority if (sum > lim_pos) begin
      clamped = ipid_pkg::DRIVE_W'(lim_pos);
    end else if (sum < lim_neg) begin
      clamped = ipid_pkg::DRIVE_W'(lim_neg);
    end else begin
      clamped = ipid_pkg::DRIVE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ipid_pkg::CHANNELS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (mv3) begin
      acc_r[s2_ch_r] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      out_drive_r <= clamped;
    end
  end

  assign out_tdata = out_drive_r;

`ifndef ASSERT_OFF
  // the stored drive never leaves the clamp window
  a_clamp_window: assert property (@(posedge clk) disable iff (!rst_n)
    mv3 |-> (ipid_pkg::SUM_W'(clamped) <= lim_pos) &&
            (ipid_pkg::SUM_W'(clamped) >= lim_neg))
    else $error("drive value outside output limit");

  // history of the channel just advanced holds the new error and the old one
  a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
    mv1 |=> (prev_err_r[s1_ch_r] == $past(err)) &&
            (prev2_err_r[s1_ch_r] == $past(e1)))
    else $error("error history not shifted");

  // the result register holds what the accumulator took
  a_result_matches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    mv3 |=> out_valid_r && (out_drive_r == $past(clamped)))
    else $error("result differs from stored drive");
`endif

endmodule
